@@ hdl/rslm_pkg.sv @@
package rslm_pkg;

    localparam int unsigned SampleW   = 12;
    localparam int unsigned CodeW     = 16;
    localparam int unsigned SmallW    = 7;
    localparam int unsigned WinW      = 11;
    localparam int unsigned StepW     = 16;
    localparam int unsigned CfgDataW  = 16;
    localparam int unsigned SumW      = 34;
    localparam int unsigned CountW    = 10;
    localparam int unsigned DivW      = SumW + 8;
    localparam int unsigned QuotW     = 32;
    localparam int unsigned MantW     = 31;
    localparam int unsigned LogW      = 20;
    localparam int unsigned ProdW     = 39;
    localparam int unsigned IterW     = 6;

    localparam logic [WinW-1:0]   MaxWindow    = 11'd1024;
    localparam logic [CodeW-1:0]  Midscale     = 16'd32768;
    localparam logic [SmallW-1:0] MaxSteps     = 7'd100;
    localparam logic [18:0]       DbPerOctave  = 19'd394566;
    localparam logic [LogW-1:0]   FullLog      = 20'd983040;

    typedef enum logic {
        CFG_WINDOW_LENGTH = 1'b0,
        CFG_LEVEL_STEP    = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT,
        ST_INT,
        ST_LOG,
        ST_LVL_MUL,
        ST_LVL_FIN,
        ST_OUT
    } t_state;

endpackage

@@ hdl/rslm_sample_if.sv @@
interface rslm_sample_if;
    logic                          valid;
    logic                          ready;
    logic [rslm_pkg::SampleW-1:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

@@ hdl/rslm_result_if.sv @@
interface rslm_result_if;
    logic                         valid;
    logic                         ready;
    logic [rslm_pkg::CodeW-1:0]  rms_code;
    logic [rslm_pkg::CodeW-1:0]  magnitude;
    logic [rslm_pkg::SmallW-1:0] intensity;
    logic [rslm_pkg::SmallW-1:0] level;
    modport source (output valid, output rms_code, output magnitude, output intensity,
                    output level, input ready);
    modport sink   (input valid, input rms_code, input magnitude, input intensity,
                    input level, output ready);
endinterface

@@ hdl/rslm_cfg_if.sv @@
interface rslm_cfg_if;
    logic                           valid;
    logic                           ready;
    rslm_pkg::t_cfg_idx             index;
    logic [rslm_pkg::CfgDataW-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/rms_sound_level_meter_core.sv @@
// windowed rms sound level meter: each accepted sample request adds its square to a
// running sum; after window_length samples the block computes one result (rms in q12.4
// codes, magnitude from midscale, intensity step count, level in dbfs plus 100) and clears
// the sum. a sample that does not close the window is taken in the idle state, so such samples can
// follow back to back. a window-closing sample keeps the sample input busy through these
// serial steps in order: restoring division, bit-pair square root, intensity stepping
// (one step at a time, capped at 100), log2 squaring, the level multiply and rounding,
// and the handoff of the result to the output register. these serial loops on the
// shared datapath set the time. the finished result waits in the output register, so
// samples of the next window are taken meanwhile; the sequencer only holds if a second
// result is ready while the first is still not taken. config writes are always taken and
// must only be issued while no window is being computed.
module rms_sound_level_meter_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rslm_sample_if.sink      i_smp,
    rslm_cfg_if.sink         i_cfg,
    rslm_result_if.source    o_res
);

    // configuration
    logic [rslm_pkg::WinW-1:0]   r_win_len;
    logic [rslm_pkg::StepW-1:0]  r_step;

    // accumulation state
    logic [rslm_pkg::SumW-1:0]   r_sum,  n_sum;
    logic [rslm_pkg::CountW-1:0] r_cnt,  n_cnt;

    // sequencer and shared datapath registers
    rslm_pkg::t_state            r_state, n_state;
    logic [rslm_pkg::IterW-1:0]  r_iter,  n_iter;
    logic [rslm_pkg::WinW-1:0]   r_n,     n_n;
    logic [rslm_pkg::DivW-1:0]   r_dq,    n_dq;
    logic [rslm_pkg::WinW-1:0]   r_rem,   n_rem;
    logic [rslm_pkg::QuotW-1:0]  r_root,  n_root;
    logic [rslm_pkg::QuotW:0]    r_bit,   n_bit;
    logic [17:0]                 r_acc,   n_acc;
    logic [rslm_pkg::MantW-1:0]  r_y,     n_y;
    logic [rslm_pkg::LogW-1:0]   r_log,   n_log;
    logic [rslm_pkg::ProdW-1:0]  r_prod,  n_prod;

    // result registers
    logic [rslm_pkg::CodeW-1:0]  r_rms,   n_rms;
    logic [rslm_pkg::CodeW-1:0]  r_mag,   n_mag;
    logic [rslm_pkg::SmallW-1:0] r_inten, n_inten;
    logic [rslm_pkg::SmallW-1:0] r_level, n_level;

    // output register, decouples a waiting result from the sample input
    logic                        r_out_vld;
    logic [rslm_pkg::CodeW-1:0]  r_out_rms;
    logic [rslm_pkg::CodeW-1:0]  r_out_mag;
    logic [rslm_pkg::SmallW-1:0] r_out_inten;
    logic [rslm_pkg::SmallW-1:0] r_out_level;

    // combinational helpers
    logic [rslm_pkg::WinW-1:0]   win_eff;
    logic [rslm_pkg::StepW-1:0]  step_eff;
    logic [rslm_pkg::WinW-1:0]   n_samples;
    logic [2*rslm_pkg::SampleW-1:0] smp_sq;
    logic [rslm_pkg::WinW:0]     div_trial;
    logic [rslm_pkg::QuotW:0]    sqrt_trial;
    logic [3:0]                  lead;
    logic [61:0]                 y_sq;
    logic [rslm_pkg::CodeW-1:0]  rms_sat;
    logic [rslm_pkg::CodeW-1:0]  mag_calc;
    logic [40:0]                 lvl_q32;
    logic                        smp_req;
    logic                        out_free;

    assign smp_req     = i_smp.valid && i_smp.ready;
    assign i_smp.ready = (r_state == rslm_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;

    // output register can take a new result when empty or being emptied
    assign out_free = !r_out_vld || o_res.ready;

    assign o_res.valid     = r_out_vld;
    assign o_res.rms_code  = r_out_rms;
    assign o_res.magnitude = r_out_mag;
    assign o_res.intensity = r_out_inten;
    assign o_res.level     = r_out_level;

    // window length and step clamped to their legal ranges
    always_comb begin
        if (r_win_len == '0) begin
            win_eff = rslm_pkg::WinW'(1);
        end else if (r_win_len > rslm_pkg::MaxWindow) begin
            win_eff = rslm_pkg::MaxWindow;
        end else begin
            win_eff = r_win_len;
        end
        step_eff = (r_step == '0) ? rslm_pkg::StepW'(1) : r_step;
    end

    assign n_samples  = {1'b0, r_cnt} + rslm_pkg::WinW'(1);
    assign smp_sq     = i_smp.sample * i_smp.sample;
    // one restoring division step: shift in the next dividend bit
    assign div_trial  = {r_rem, r_dq[rslm_pkg::DivW-1]} - {1'b0, r_n};
    // one square root step: compare against root plus the current bit pair
    assign sqrt_trial = {1'b0, r_dq[rslm_pkg::QuotW-1:0]} - ({1'b0, r_root} + r_bit);
    assign y_sq       = {31'b0, r_y} * {31'b0, r_y};
    assign rms_sat    = (r_root > 32'h0000_FFFF) ? 16'hFFFF : r_root[15:0];
    assign mag_calc   = (rms_sat >= rslm_pkg::Midscale) ? rms_sat - rslm_pkg::Midscale
                                                        : rslm_pkg::Midscale - rms_sat;
    // 100 in q32 minus the loss
    assign lvl_q32    = {2'b0, 7'd100, 32'b0} - {2'b0, r_prod};

    // leading one of the magnitude, capped at bit 15
    always_comb begin
        lead = '0;
        for (int i = 1; i < 16; i++) begin
            if (r_mag[i]) begin
                lead = 4'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_sum   = r_sum;
        n_cnt   = r_cnt;
        n_iter  = r_iter;
        n_n     = r_n;
        n_dq    = r_dq;
        n_rem   = r_rem;
        n_root  = r_root;
        n_bit   = r_bit;
        n_acc   = r_acc;
        n_y     = r_y;
        n_log   = r_log;
        n_prod  = r_prod;
        n_rms   = r_rms;
        n_mag   = r_mag;
        n_inten = r_inten;
        n_level = r_level;
        unique case (r_state)
            rslm_pkg::ST_IDLE: begin
                if (smp_req) begin
                    if (n_samples < win_eff) begin
                        n_sum = r_sum + rslm_pkg::SumW'(smp_sq);
                        n_cnt = n_samples[rslm_pkg::CountW-1:0];
                    end else begin
                        // window closes: load dividend 256*sum, clear the accumulator
                        n_dq    = {r_sum + rslm_pkg::SumW'(smp_sq), 8'b0};
                        n_n     = n_samples;
                        n_rem   = '0;
                        n_iter  = '0;
                        n_sum   = '0;
                        n_cnt   = '0;
                        n_state = rslm_pkg::ST_DIV;
                    end
                end
            end
            rslm_pkg::ST_DIV: begin
                if (!div_trial[rslm_pkg::WinW]) begin
                    n_rem = div_trial[rslm_pkg::WinW-1:0];
                    n_dq  = {r_dq[rslm_pkg::DivW-2:0], 1'b1};
                end else begin
                    n_rem = {r_rem[rslm_pkg::WinW-2:0], r_dq[rslm_pkg::DivW-1]};
                    n_dq  = {r_dq[rslm_pkg::DivW-2:0], 1'b0};
                end
                n_iter = r_iter + 1'b1;
                if (r_iter == rslm_pkg::IterW'(rslm_pkg::DivW - 1)) begin
                    n_root  = '0;
                    n_bit   = {3'b001, 30'b0};
                    n_iter  = '0;
                    n_state = rslm_pkg::ST_SQRT;
                end
            end
            rslm_pkg::ST_SQRT: begin
                // quotient stays in the low bits of r_dq as the running remainder
                if (!sqrt_trial[rslm_pkg::QuotW]) begin
                    n_dq   = {r_dq[rslm_pkg::DivW-1:rslm_pkg::QuotW],
                              sqrt_trial[rslm_pkg::QuotW-1:0]};
                    n_root = (r_root >> 1) + r_bit[rslm_pkg::QuotW-1:0];
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit  = r_bit >> 2;
                n_iter = r_iter + 1'b1;
                if (r_iter == rslm_pkg::IterW'(15)) begin
                    n_state = rslm_pkg::ST_INT;
                end
            end
            rslm_pkg::ST_INT: begin
                if (r_iter == rslm_pkg::IterW'(16)) begin
                    // first cycle here: latch rms and magnitude, start step count
                    n_rms   = rms_sat;
                    n_mag   = mag_calc;
                    n_acc   = {2'b0, step_eff};
                    n_inten = '0;
                    n_iter  = '0;
                end else if (r_inten < rslm_pkg::MaxSteps && r_acc < {2'b0, r_mag}) begin
                    n_inten = r_inten + 1'b1;
                    n_acc   = r_acc + {2'b0, step_eff};
                end else begin
                    n_y     = rslm_pkg::MantW'({15'b0, r_mag} << (5'd30 - {1'b0, lead}));
                    n_log   = {lead, 16'b0};
                    n_iter  = '0;
                    n_state = rslm_pkg::ST_LOG;
                end
            end
            rslm_pkg::ST_LOG: begin
                // one fraction bit of log2 per squaring
                if (y_sq[61]) begin
                    n_y   = y_sq[61:31];
                    n_log = r_log | rslm_pkg::LogW'(20'h08000 >> r_iter[3:0]);
                end else begin
                    n_y   = y_sq[60:30];
                end
                n_iter = r_iter + 1'b1;
                if (r_iter == rslm_pkg::IterW'(15)) begin
                    n_state = rslm_pkg::ST_LVL_MUL;
                end
            end
            rslm_pkg::ST_LVL_MUL: begin
                n_prod  = {19'b0, rslm_pkg::FullLog - r_log} * {20'b0, rslm_pkg::DbPerOctave};
                n_state = rslm_pkg::ST_LVL_FIN;
            end
            rslm_pkg::ST_LVL_FIN: begin
                if (r_mag == '0) begin
                    n_level = '0;
                end else if (r_log >= rslm_pkg::FullLog) begin
                    n_level = rslm_pkg::MaxSteps;
                end else begin
                    n_level = rslm_pkg::SmallW'((lvl_q32 + 41'h0_8000_0000) >> 32);
                end
                n_state = rslm_pkg::ST_OUT;
            end
            rslm_pkg::ST_OUT: begin
                // hand the result over once the output register is free
                if (out_free) begin
                    n_state = rslm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rslm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rslm_pkg::ST_IDLE;
            r_sum     <= '0;
            r_cnt     <= '0;
            r_win_len <= rslm_pkg::WinW'(10);
            r_step    <= rslm_pkg::StepW'(328);
            r_iter    <= '0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_cnt   <= n_cnt;
            r_iter  <= n_iter;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    rslm_pkg::CFG_WINDOW_LENGTH: r_win_len <= i_cfg.data[rslm_pkg::WinW-1:0];
                    rslm_pkg::CFG_LEVEL_STEP:    r_step    <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_dq    <= n_dq;
        r_rem   <= n_rem;
        r_root  <= n_root;
        r_bit   <= n_bit;
        r_acc   <= n_acc;
        r_y     <= n_y;
        r_log   <= n_log;
        r_prod  <= n_prod;
        r_rms   <= n_rms;
        r_mag   <= n_mag;
        r_inten <= n_inten;
        r_level <= n_level;
    end

    // output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == rslm_pkg::ST_OUT && out_free) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rslm_pkg::ST_OUT && out_free) begin
            r_out_rms   <= r_rms;
            r_out_mag   <= r_mag;
            r_out_inten <= r_inten;
            r_out_level <= r_level;
        end
    end

endmodule

@@ hdl/rslm_checker.sv @@
module rslm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_rms,
    input logic [15:0] i_mag,
    input logic [6:0]  i_inten,
    input logic [6:0]  i_level
);

    // a pending result stays valid, with rms and level stable, until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_rms) && $stable(i_level))
        else $error("result dropped or changed while stalled");

    // reset leaves no result pending and the sample input open
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("block not idle after reset");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_inten <= 7'd100 && i_level <= 7'd100)
        else $error("intensity or level out of range");

    a_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_rms >= 16'd32768 && i_mag == i_rms - 16'd32768) ||
                        (i_rms < 16'd32768 && i_mag == 16'd32768 - i_rms))
        else $error("magnitude does not match rms");

endmodule

bind rms_sound_level_meter_core rslm_checker u_rslm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_rms       (o_res.rms_code),
    .i_mag       (o_res.magnitude),
    .i_inten     (o_res.intensity),
    .i_level     (o_res.level)
);
